// ===== rtl/fit_block_allocator_top_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define FBA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define FBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fba_pkg.sv =====
// Types and constants of the fit block allocator.
package fba_pkg;

   localparam int FIELD_W       = 16;
   localparam int INDEX_W       = 4;
   localparam int FIT_MODE_W    = 2;
   localparam int BLOCK_COUNT_W = 5;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

   // action field
   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_REQUEST = 1'b1;

   // placement policies; the unused code behaves as first fit
   localparam logic [FIT_MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [FIT_MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [FIT_MODE_W-1:0] FIT_WORST = 2'd2;

   // register select, taken from paddr bit 2
   localparam logic CSR_SEL_FIT_MODE    = 1'b0;
   localparam logic CSR_SEL_BLOCK_COUNT = 1'b1;

   typedef struct packed {
      logic               action;
      logic [INDEX_W-1:0] block_index;
      logic [FIELD_W-1:0] block_capacity;
      logic [FIELD_W-1:0] request_size;
      logic               last_file;
   } req_type;

   typedef struct packed {
      logic               granted;
      logic [INDEX_W-1:0] chosen_block;
      logic [FIELD_W-1:0] capacity_before;
      logic [FIELD_W-1:0] capacity_after;
      logic               batch_end;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic load_write;
      logic scan_step;
      logic update;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } ctrl_status_type;

endpackage

// ===== rtl/fit_block_allocator_top.sv =====
// Fit block allocator: capacity table with first, best and worst fit placement.
//
// Keeps the remaining capacity of NUM_BLOCKS blocks in a small RAM. A load
// request (action 0) writes one block's capacity and gives no result;
// loads to an index at or above NUM_BLOCKS are dropped. An
// allocation request (action 1) scans blocks 0 .. min(block_count,
// NUM_BLOCKS)-1 one entry per cycle through the table's single read port,
// picks the first, smallest or largest block that fits (ties to the lowest
// index) and writes back the reduced capacity. The next request is taken
// only after the result is loaded, so one request is handled at a time.
// The result sits in an output register, so the next request is taken while
// a result still waits on rsp_ready. The table reads as all zero after reset
// through per-block written flags; there is no clearing pass. Registers
// fit_mode (byte address 0) and block_count (byte address 4) must be written
// over the APB port only while the block is idle; keeping to this is left to
// the user, as the block has no check of it. fit_mode 3 acts as first fit
// and a block_count of 0 refuses every request.
module fit_block_allocator_top #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fba_pkg::req_type                   req_payload,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fba_pkg::rsp_type                   rsp_payload,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fba_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fba_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fba_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   import fba_pkg::*;

   logic [FIT_MODE_W-1:0]    fit_mode_ff,    fit_mode_in;
   logic [BLOCK_COUNT_W-1:0] block_count_ff, block_count_in;
   logic                     csr_write;
   ctrl_cmd_type             cmd;
   ctrl_status_type          status;

   // register file: decode on address bit 2, word offsets ignored
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      fit_mode_in    = fit_mode_ff;
      block_count_in = block_count_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_SEL_FIT_MODE:    fit_mode_in    = pwdata[FIT_MODE_W-1:0];
            CSR_SEL_BLOCK_COUNT: block_count_in = pwdata[BLOCK_COUNT_W-1:0];
            default: begin
               fit_mode_in = fit_mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_SEL_FIT_MODE:    prdata = CSR_DATA_W'(fit_mode_ff);
         CSR_SEL_BLOCK_COUNT: prdata = CSR_DATA_W'(block_count_ff);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= FIT_FIRST;
         block_count_ff <= BLOCK_COUNT_RESET;
      end else begin
         fit_mode_ff    <= fit_mode_in;
         block_count_ff <= block_count_in;
      end
   end

   // sequencer
   fba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_payload.action),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .status     (status)
   );

   // table, search and result register
   fba_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .fit_mode    (fit_mode_ff),
      .block_count (block_count_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/fba_ram.sv =====
// Generic single write port RAM with one registered read port.
module fba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fba_ctrl.sv =====
// Sequencer of the allocator: load, scan and update steps.
`include "fit_block_allocator_top_macros.svh"

module fba_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_action,
   output logic                     req_ready,
   output fba_pkg::ctrl_cmd_type    cmd,
   input  fba_pkg::ctrl_status_type status
);

   import fba_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_action == ACT_REQUEST) ? ST_SCAN : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // wait for the result register to free up
            if (status.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   `FBA_ASSERT_NEXT(a_load_one_cycle, clock, reset, state_ff == ST_LOAD, state_ff == ST_IDLE, "load step did not return to idle")
   `FBA_ASSERT_NOW(a_update_needs_room, clock, reset, cmd.update, status.out_free, "result written over a waiting result")
   `FBA_ASSERT_NEXT(a_request_scans, clock, reset, cmd.capture && (req_action == ACT_REQUEST), state_ff == ST_SCAN, "request did not start a scan")

endmodule

// ===== rtl/fba_datapath.sv =====
// Capacity table, serial fit search and result register.
`include "fit_block_allocator_top_macros.svh"

module fba_datapath #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fba_pkg::req_type                      req_payload,
   input  fba_pkg::ctrl_cmd_type                 cmd,
   output fba_pkg::ctrl_status_type              status,
   input  logic [fba_pkg::FIT_MODE_W-1:0]        fit_mode,
   input  logic [fba_pkg::BLOCK_COUNT_W-1:0]     block_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output fba_pkg::rsp_type                      rsp_payload
);

   import fba_pkg::*;

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int LIM_W = (CNT_W > BLOCK_COUNT_W) ? CNT_W : BLOCK_COUNT_W;

   // held item
   logic                  last_ff,     last_in;
   logic [INDEX_W-1:0]    load_idx_ff, load_idx_in;
   logic [SIZE_WIDTH-1:0] load_cap_ff, load_cap_in;
   logic [SIZE_WIDTH-1:0] size_ff,     size_in;

   // scan control
   logic [LIM_W-1:0]      limit_ff,     limit_in;
   logic [LIM_W-1:0]      issue_cnt_ff, issue_cnt_in;
   logic                  rd_pend_ff,   rd_pend_in;
   logic                  rd_ok_ff,     rd_ok_in;
   logic [IDX_W-1:0]      rd_idx_ff,    rd_idx_in;
   logic                  found_ff,     found_in;
   logic [IDX_W-1:0]      best_idx_ff,  best_idx_in;
   logic [SIZE_WIDTH-1:0] best_val_ff,  best_val_in;

   logic [NUM_BLOCKS-1:0] valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [FIELD_W+SIZE_WIDTH-1:0] cap_wide, size_wide;
   logic [SIZE_WIDTH+FIELD_W-1:0] before_wide, after_wide;
   logic [IDX_W+INDEX_W-1:0]      load_addr_wide;
   logic [INDEX_W+IDX_W-1:0]      chosen_wide;
   logic [LIM_W-1:0]              count_ext;
   logic [SIZE_WIDTH-1:0]         entry_val, after_val;
   logic [IDX_W-1:0]              wr_addr, rd_addr;
   logic [SIZE_WIDTH-1:0]         wr_data, rd_data;
   logic                          wr_en, issue_go, load_ok, fits, better, take;

   assign cap_wide       = {{SIZE_WIDTH{1'b0}}, req_payload.block_capacity};
   assign size_wide      = {{SIZE_WIDTH{1'b0}}, req_payload.request_size};
   assign load_addr_wide = {{IDX_W{1'b0}}, load_idx_ff};
   assign count_ext      = LIM_W'(block_count);
   assign load_ok        = LIM_W'(load_idx_ff) < LIM_W'(NUM_BLOCKS);

   // issue side of the scan
   assign issue_go = cmd.scan_step && (issue_cnt_ff != limit_ff);
   assign rd_addr  = issue_cnt_ff[IDX_W-1:0];

   // compare side: an entry never written reads as zero
   assign entry_val = rd_ok_ff ? rd_data : '0;
   assign fits      = entry_val >= size_ff;

   always_comb begin
      case (fit_mode)
         FIT_BEST:  better = entry_val < best_val_ff;
         FIT_WORST: better = entry_val > best_val_ff;
         default:   better = 1'b0;
      endcase
   end

   assign take      = rd_pend_ff && fits && (!found_ff || better);
   assign after_val = best_val_ff - size_ff;

   // single write port shared by loads and grant write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = load_addr_wide[IDX_W-1:0];
      wr_data = load_cap_ff;
      if (cmd.load_write) begin
         wr_en = load_ok;
      end else if (cmd.update) begin
         wr_en   = found_ff;
         wr_addr = best_idx_ff;
         wr_data = after_val;
      end
   end

   fba_ram #(
      .WIDTH (SIZE_WIDTH),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue_go),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign before_wide = {{FIELD_W{1'b0}}, best_val_ff};
   assign after_wide  = {{FIELD_W{1'b0}}, after_val};
   assign chosen_wide = {{INDEX_W{1'b0}}, best_idx_ff};

   always_comb begin
      last_in      = last_ff;
      load_idx_in  = load_idx_ff;
      load_cap_in  = load_cap_ff;
      size_in      = size_ff;
      limit_in     = limit_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_pend_in   = issue_go;
      rd_ok_in     = valid_ff[rd_addr];
      rd_idx_in    = rd_addr;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (cmd.capture) begin
         last_in      = req_payload.last_file;
         load_idx_in  = req_payload.block_index;
         load_cap_in  = cap_wide[SIZE_WIDTH-1:0];
         size_in      = size_wide[SIZE_WIDTH-1:0];
         limit_in     = (count_ext < LIM_W'(NUM_BLOCKS)) ? count_ext : LIM_W'(NUM_BLOCKS);
         issue_cnt_in = '0;
         rd_pend_in   = 1'b0;
         found_in     = 1'b0;
      end

      if (issue_go) begin
         issue_cnt_in = issue_cnt_ff + 1'b1;
      end

      if (take) begin
         found_in    = 1'b1;
         best_idx_in = rd_idx_ff;
         best_val_in = entry_val;
      end

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.update) begin
         rsp_valid_in           = 1'b1;
         rsp_in.granted         = found_ff;
         rsp_in.chosen_block    = found_ff ? chosen_wide[INDEX_W-1:0] : '0;
         rsp_in.capacity_before = found_ff ? before_wide[FIELD_W-1:0] : '0;
         rsp_in.capacity_after  = found_ff ? after_wide[FIELD_W-1:0] : '0;
         rsp_in.batch_end       = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= '0;
         issue_cnt_ff <= '0;
         rd_pend_ff   <= 1'b0;
         found_ff     <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         found_ff     <= found_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      load_idx_ff <= load_idx_in;
      load_cap_ff <= load_cap_in;
      size_ff     <= size_in;
      rd_ok_ff    <= rd_ok_in;
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      rsp_ff      <= rsp_in;
   end

   assign status.scan_done = (issue_cnt_ff == limit_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_ff;

   `FBA_ASSERT_NOW(a_best_fits, clock, reset, found_ff, best_val_ff >= size_ff, "held candidate smaller than request")
   `FBA_ASSERT_NOW(a_scan_bounded, clock, reset, 1'b1, issue_cnt_ff <= limit_ff, "scan ran past the block limit")
   `FBA_ASSERT_NOW(a_refusal_zero, clock, reset, rsp_valid_ff && !rsp_ff.granted, (rsp_ff.chosen_block == '0) && (rsp_ff.capacity_before == '0) && (rsp_ff.capacity_after == '0), "refused request carries block data")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the fit block allocator: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
   import fba_pkg::*;

   // Same table depth as the block is built with.
   localparam int TABLE_DEPTH = 16;
   // fit_mode 3 has no name in the package; the block treats it as first fit.
   localparam logic [FIT_MODE_W-1:0] FIT_UNUSED = 2'd3;

   // The settle wait outlasts a full scan and a load, so it leaves the block
   // quiet even when the last requests gave no result.
   localparam int SETTLE_CYCLES   = 40;
   localparam int PHASE_COUNT     = 11;
   localparam int PHASE_ITEMS     = 100;
   // Long receiver stall in one phase, so the output register and the
   // scan both fill and req_ready drops while the sender keeps offering.
   localparam int HOLD_PHASE      = 1;
   localparam int HOLD_CYCLES     = 400;
   // Cycles without any handshake before the run is declared hung.
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int MAX_REPORTS     = 100;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      item;
      logic         csr_sel;
      logic [31:0]  csr_value;
      bit           typed;
      rsp_type      want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Our own copy of the capacity table and of the two registers.
   logic [FIELD_W-1:0]       remaining [TABLE_DEPTH];
   logic [FIT_MODE_W-1:0]    placement;
   logic [BLOCK_COUNT_W-1:0] blocks_in_use;

   rsp_type     grant_queue [$];
   dir_row_type directed_steps [$];
   rsp_type     oldest_grant;

   int mismatch_count;
   int load_count;
   int request_count;
   int granted_seen;
   int refused_seen;
   int setting_count;
   int send_idle_pct;
   int recv_idle_pct;
   int phase_no;
   int hold_left;
   bit hold_done;
   int quiet_cycles;

   fit_block_allocator_top #(
      .NUM_BLOCKS (TABLE_DEPTH),
      .SIZE_WIDTH (FIELD_W)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   // Placement decision for one allocation request: scans the blocks in use,
   // keeps the first fit, or the smallest / largest fit with ties going to
   // the lower index, and takes the size off the winner.
   function automatic rsp_type compute_grant(input req_type item);
      rsp_type     g;
      int unsigned span;
      int          pick;
      int          j;
      g           = '0;
      g.batch_end = item.last_file;
      span        = (blocks_in_use > TABLE_DEPTH) ? TABLE_DEPTH : blocks_in_use;
      pick        = -1;
      for (j = 0; j < span; j++) begin
         if (remaining[j] >= item.request_size) begin
            if (pick < 0)
               pick = j;
            else if (placement == FIT_BEST && remaining[j] < remaining[pick])
               pick = j;
            else if (placement == FIT_WORST && remaining[j] > remaining[pick])
               pick = j;
         end
      end
      if (pick >= 0) begin
         g.granted         = 1'b1;
         g.chosen_block    = pick[INDEX_W-1:0];
         g.capacity_before = remaining[pick];
         g.capacity_after  = remaining[pick] - item.request_size;
         remaining[pick]   = g.capacity_after;
      end
      return g;
   endfunction

   // Called at the edge where a request is taken: loads update the table,
   // allocation requests queue their expected result (typed-in or predicted;
   // the prediction always runs so the table stays in step).
   task automatic record_accepted(input req_type item, input bit typed, input rsp_type want);
      rsp_type g;
      if (item.action == ACT_LOAD) begin
         remaining[item.block_index] = item.block_capacity;
         load_count++;
      end else begin
         g = compute_grant(item);
         grant_queue.push_back(typed ? want : g);
         request_count++;
      end
   endtask

   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      record_accepted(item, typed, want);
   endtask

   // Drop valid, wait for every outstanding result, then let any trailing
   // load finish before the registers are touched.
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (grant_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apb_cycle(input logic sel, input logic wr, input logic [31:0] value,
                            output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Write a register, mirror it, and read it back.
   task automatic csr_write(input logic sel, input logic [31:0] value);
      logic [31:0] rdata;
      logic [31:0] mask;
      mask = (sel == CSR_SEL_FIT_MODE) ? (32'd1 << FIT_MODE_W) - 1 :
                                         (32'd1 << BLOCK_COUNT_W) - 1;
      apb_cycle(sel, 1'b1, value, rdata);
      if (sel == CSR_SEL_FIT_MODE)
         placement = value[FIT_MODE_W-1:0];
      else
         blocks_in_use = value[BLOCK_COUNT_W-1:0];
      setting_count++;
      apb_cycle(sel, 1'b0, '0, rdata);
      if (rdata !== (value & mask))
         report_mismatch(sel == CSR_SEL_FIT_MODE ? "fit_mode readback" :
                         "block_count readback", rdata, value & mask);
   endtask

   function automatic req_type make_req(input logic act, input logic [INDEX_W-1:0] idx,
                                        input logic [FIELD_W-1:0] cap,
                                        input logic [FIELD_W-1:0] size, input logic last);
      req_type r;
      r.action         = act;
      r.block_index    = idx;
      r.block_capacity = cap;
      r.request_size   = size;
      r.last_file      = last;
      return r;
   endfunction

   function automatic rsp_type make_rsp(input logic g, input logic [INDEX_W-1:0] blk,
                                        input logic [FIELD_W-1:0] before_cap,
                                        input logic [FIELD_W-1:0] after_cap,
                                        input logic last);
      rsp_type r;
      r.granted         = g;
      r.chosen_block    = blk;
      r.capacity_before = before_cap;
      r.capacity_after  = after_cap;
      r.batch_end       = last;
      return r;
   endfunction

   task automatic add_item(input req_type item, input bit typed, input rsp_type want);
      dir_row_type row;
      row.kind      = ROW_ITEM;
      row.item      = item;
      row.csr_sel   = 1'b0;
      row.csr_value = '0;
      row.typed     = typed;
      row.want      = want;
      directed_steps.push_back(row);
   endtask

   task automatic add_csr(input logic sel, input logic [31:0] value);
      dir_row_type row;
      row.kind      = ROW_CSR;
      row.item      = '0;
      row.csr_sel   = sel;
      row.csr_value = value;
      row.typed     = 1'b0;
      row.want      = '0;
      directed_steps.push_back(row);
   endtask

   // Random capacity: mostly modest values, some coarse steps to force ties
   // in best / worst fit, some full-range and the two extremes.
   function automatic logic [FIELD_W-1:0] random_capacity();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      return FIELD_W'($urandom_range(0, 1023));
      else if (pick < 60) return FIELD_W'($urandom_range(1, 4) * 256);
      else if (pick < 90) return FIELD_W'($urandom_range(0, 65535));
      else if (pick < 95) return '0;
      else                return '1;
   endfunction

   // Random request item. Sizes lean small so most requests are granted and
   // the table drains gradually; some match a stored capacity exactly.
   function automatic req_type random_item();
      req_type r;
      int      pick;
      r = make_req($urandom_range(0, 99) < 30 ? ACT_LOAD : ACT_REQUEST,
                   INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), random_capacity(),
                   FIELD_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 99);
      if (pick < 10)      r.request_size = '0;
      else if (pick < 55) r.request_size = FIELD_W'($urandom_range(1, 300));
      else if (pick < 70) r.request_size = remaining[$urandom_range(0, TABLE_DEPTH - 1)];
      else if (pick < 90) r.request_size = FIELD_W'($urandom_range(0, 65535));
      else                r.request_size = '1;
      return r;
   endfunction

   // Result side: random back-pressure, plus one long hold-off counted here.
   always @(negedge clock) begin
      if (phase_no == HOLD_PHASE && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Scoreboard: every accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (grant_queue.size() == 0) begin
            report_mismatch("result with nothing outstanding", rsp_payload, '0);
         end else begin
            oldest_grant = grant_queue.pop_front();
            if (rsp_payload.granted) granted_seen++;
            else                     refused_seen++;
            if (rsp_payload.granted !== oldest_grant.granted)
               report_mismatch("granted", rsp_payload.granted, oldest_grant.granted);
            if (rsp_payload.chosen_block !== oldest_grant.chosen_block)
               report_mismatch("chosen_block", rsp_payload.chosen_block,
                               oldest_grant.chosen_block);
            if (rsp_payload.capacity_before !== oldest_grant.capacity_before)
               report_mismatch("capacity_before", rsp_payload.capacity_before,
                               oldest_grant.capacity_before);
            if (rsp_payload.capacity_after !== oldest_grant.capacity_after)
               report_mismatch("capacity_after", rsp_payload.capacity_after,
                               oldest_grant.capacity_after);
            if (rsp_payload.batch_end !== oldest_grant.batch_end)
               report_mismatch("batch_end", rsp_payload.batch_end, oldest_grant.batch_end);
         end
      end
   end

   // Hang detector: any handshake or register access counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: %0d cycles without progress, %0d results outstanding",
                  quiet_cycles, grant_queue.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          p;
      int          k;
      logic [1:0]  mode_sel;
      logic [31:0] count_sel;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      rsp_ready      = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      placement      = FIT_FIRST;
      blocks_in_use  = BLOCK_COUNT_RESET;
      mismatch_count = 0;
      load_count     = 0;
      request_count  = 0;
      granted_seen   = 0;
      refused_seen   = 0;
      setting_count  = 0;
      phase_no       = -1;
      hold_left      = 0;
      hold_done      = 1'b0;
      quiet_cycles   = 0;
      send_idle_pct  = 24;
      recv_idle_pct  = 79;
      for (k = 0; k < TABLE_DEPTH; k++)
         remaining[k] = '0;

      // Directed table. Expectations are typed in where they are obvious;
      // rows with a zero "typed" flag go through the predictor.
      // Fresh table, first fit over all 16 blocks:
      // size 0 fits an empty block, anything larger fits nowhere.
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'h0000, 1'b1), 1,
               make_rsp(1'b1, 4'h0, 16'h0000, 16'h0000, 1'b1));
      add_item(make_req(ACT_REQUEST, 4'hF, 16'hFFFF, 16'h0001, 1'b0), 1,
               make_rsp(1'b0, 4'h0, 16'h0000, 16'h0000, 1'b0));
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'hFFFF, 1'b1), 1,
               make_rsp(1'b0, 4'h0, 16'h0000, 16'h0000, 1'b1));
      // Full capacity in the first and last block, each taken whole.
      add_item(make_req(ACT_LOAD, 4'h0, 16'hFFFF, 16'h0000, 1'b0), 0, '0);
      add_item(make_req(ACT_LOAD, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1), 0, '0);
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'hFFFF, 1'b0), 1,
               make_rsp(1'b1, 4'h0, 16'hFFFF, 16'h0000, 1'b0));
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'hFFFF, 1'b1), 1,
               make_rsp(1'b1, 4'hF, 16'hFFFF, 16'h0000, 1'b1));
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'h0001, 1'b0), 1,
               make_rsp(1'b0, 4'h0, 16'h0000, 16'h0000, 1'b0));
      // A mixed table with a tie at 50 for best fit.
      add_item(make_req(ACT_LOAD, 4'd3,  16'd100, 16'h0000, 1'b0), 0, '0);
      add_item(make_req(ACT_LOAD, 4'd7,  16'd50,  16'h0000, 1'b0), 0, '0);
      add_item(make_req(ACT_LOAD, 4'd9,  16'd200, 16'h0000, 1'b0), 0, '0);
      add_item(make_req(ACT_LOAD, 4'd12, 16'd50,  16'h0000, 1'b0), 0, '0);
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'd40, 1'b0), 1,
               make_rsp(1'b1, 4'd3, 16'd100, 16'd60, 1'b0));
      add_csr(CSR_SEL_FIT_MODE, FIT_BEST);
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'd50, 1'b1), 1,
               make_rsp(1'b1, 4'd7, 16'd50, 16'd0, 1'b1));
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'd10, 1'b0), 0, '0);
      add_csr(CSR_SEL_FIT_MODE, FIT_WORST);
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'd10, 1'b0), 1,
               make_rsp(1'b1, 4'd9, 16'd200, 16'd190, 1'b0));
      // Unused policy code behaves as first fit.
      add_csr(CSR_SEL_FIT_MODE, FIT_UNUSED);
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'd5, 1'b0), 0, '0);
      // No blocks in use refuses even a zero size; one block takes it.
      add_csr(CSR_SEL_BLOCK_COUNT, 32'd0);
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'd0, 1'b1), 1,
               make_rsp(1'b0, 4'h0, 16'h0000, 16'h0000, 1'b1));
      add_csr(CSR_SEL_BLOCK_COUNT, 32'd1);
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'd0, 1'b0), 1,
               make_rsp(1'b1, 4'h0, 16'h0000, 16'h0000, 1'b0));
      // Count above the table size searches all blocks.
      add_csr(CSR_SEL_BLOCK_COUNT, 32'd31);
      add_csr(CSR_SEL_FIT_MODE, FIT_FIRST);
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'hFFFF, 1'b1), 0, '0);
      add_item(make_req(ACT_LOAD, 4'hF, 16'd1, 16'h0000, 1'b0), 0, '0);
      add_item(make_req(ACT_REQUEST, 4'h0, 16'h0000, 16'd1, 1'b1), 0, '0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[k]) begin
         if (directed_steps[k].kind == ROW_CSR) begin
            settle_idle();
            csr_write(directed_steps[k].csr_sel, directed_steps[k].csr_value);
         end else begin
            send_item(directed_steps[k].item, directed_steps[k].typed, directed_steps[k].want);
         end
      end

      // Random phases, each under its own register setting. Idle profile:
      // sender dense / receiver busy, then sender sparse / receiver eager, then flat out.
      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0:       begin mode_sel = FIT_FIRST;  count_sel = 16; end
            1:       begin mode_sel = FIT_BEST;   count_sel = 16; end
            2:       begin mode_sel = FIT_WORST;  count_sel = 16; end
            3:       begin mode_sel = FIT_UNUSED; count_sel = 8;  end
            4:       begin mode_sel = FIT_BEST;   count_sel = 1;  end
            5:       begin mode_sel = FIT_WORST;  count_sel = 17; end
            6:       begin mode_sel = FIT_FIRST;  count_sel = 31; end
            7:       begin mode_sel = FIT_BEST;   count_sel = 0;  end
            8:       begin mode_sel = FIT_WORST;  count_sel = 5;  end
            9:       begin mode_sel = FIT_BEST;   count_sel = 12; end
            default: begin mode_sel = FIT_FIRST;  count_sel = 16; end
         endcase
         settle_idle();
         if (p < 4) begin
            send_idle_pct = 24;
            recv_idle_pct = 79;
         end else if (p < 8) begin
            send_idle_pct = 79;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         phase_no = p;
         csr_write(CSR_SEL_FIT_MODE, mode_sel);
         csr_write(CSR_SEL_BLOCK_COUNT, count_sel);
         // Well-formed start: fill every block, then mix loads and requests.
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k < TABLE_DEPTH)
               send_item(make_req(ACT_LOAD, INDEX_W'(k), random_capacity(),
                                  FIELD_W'($urandom_range(0, 65535)),
                                  1'($urandom_range(0, 1))), 1'b0, '0);
            else
               send_item(random_item(), 1'b0, '0);
         end
      end

      settle_idle();
      $display("Covered %0d loads and %0d allocation requests (%0d granted, %0d refused)",
               load_count, request_count, granted_seen, refused_seen);
      $display("over %0d register writes: all fit policies, block counts 0 to 31, long stall",
               setting_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
